/* hw/rtl/ioapic_register_file_core_defines.svh */
// Assertion macros shared by the register file RTL.
`ifndef IOAPIC_REGISTER_FILE_CORE_DEFINES_SVH
`define IOAPIC_REGISTER_FILE_CORE_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define IORF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define IORF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/iorf_pkg.sv */
`default_nettype none

package iorf_pkg;

  localparam int NUM_ENTRIES_DEFAULT = 24;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [11:0] OFS_SELECT = 12'h000;
  localparam logic [11:0] OFS_DATA   = 12'h010;
  localparam logic [11:0] OFS_EOI    = 12'h040;

  localparam logic [7:0] IDX_ID      = 8'h00;
  localparam logic [7:0] IDX_VERSION = 8'h01;
  localparam logic [7:0] IDX_TABLE   = 8'h10;

  localparam logic [7:0]  VERSION_CODE   = 8'h20;
  localparam int          REMOTE_IRR_BIT = 14;
  localparam logic [63:0] ENTRY_RESET    = 64'h0000_0000_0001_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [7:0]  entry_number;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        ok;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/iorf_ram.sv */
`default_nettype none

module iorf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 24
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]    waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic                                          re,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]    raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ioapic_register_file_core.sv */
// Channel  Direction  Handshake             Word
// req      in         req_valid/req_stall   req_t: opcode, offset, write_data, entry_number
// rsp      out        rsp_valid/rsp_stall   rsp_t: read_data, ok
//
// Select, ID, version and unmapped accesses go from acceptance straight to the finish state.
// An access to a redirection entry passes through a read state and a merge state on the table RAM.
// An EOI scans the table RAM, one entry checked per cycle by the shared comparator.
// Reset is synchronous; entries not yet written read as masked through per-entry valid bits.
// A result waits in the output register while rsp_stall is high, and the next word may be
// accepted meanwhile.
`default_nettype none

`include "ioapic_register_file_core_defines.svh"

module ioapic_register_file_core
  import iorf_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_ENTRIES - 1);
  localparam logic [31:0] VERSION_WORD = {8'h00, 8'(NUM_ENTRIES - 1), 8'h00, VERSION_CODE};
  localparam logic [63:0] IRR_MASK = 64'(1) << REMOTE_IRR_BIT;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MERGE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINISH
  } state_t;

  state_t           state;
  logic [7:0]       select_index;
  logic [3:0]       controller_id;
  logic [1:0]       op;
  logic [31:0]      wdata;
  logic             high_half;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    cnt;
  logic [63:0]      result;
  logic             res_ok;
  logic [NUM_ENTRIES-1:0] valid;
  logic             valid_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [63:0]      ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [63:0]      ram_rdata;

  logic [7:0]       sel_rel;
  logic [6:0]       sel_num;
  logic             sel_hit;
  logic             query_hit;
  logic [63:0]      entry;
  state_t           start_state;
  logic [63:0]      start_result;

  iorf_ram #(
    .WIDTH(64),
    .DEPTH(NUM_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign sel_rel   = select_index - IDX_TABLE;
  assign sel_num   = sel_rel[7:1];
  assign sel_hit   = (select_index >= IDX_TABLE) && ({1'b0, sel_rel} < 9'(2 * NUM_ENTRIES));
  assign query_hit = req.entry_number < 8'(NUM_ENTRIES);
  assign entry     = valid_q ? ram_rdata : ENTRY_RESET;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    start_state  = S_FINISH;
    start_result = '0;
    unique case (req.opcode)
      OP_READ: begin
        if (req.offset == OFS_SELECT) begin
          start_result = {56'h0, select_index};
        end else if (req.offset == OFS_DATA) begin
          if (select_index == IDX_ID) begin
            start_result = {36'h0, controller_id, 24'h0};
          end else if (select_index == IDX_VERSION) begin
            start_result = {32'h0, VERSION_WORD};
          end else if (sel_hit) begin
            start_state = S_READ;
          end
        end
      end
      OP_WRITE: begin
        if ((req.offset == OFS_DATA) && sel_hit) begin
          start_state = S_READ;
        end else if (req.offset == OFS_EOI) begin
          start_state = S_SCAN_RD;
        end
      end
      OP_QUERY: begin
        if (query_hit) begin
          start_state = S_READ;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = entry;
    unique case (state)
      S_READ: begin
        ram_re = 1'b1;
      end
      S_MERGE: begin
        if (op == OP_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = high_half ? {wdata, entry[31:0]} : {entry[63:32], wdata};
        end
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cnt;
      end
      S_SCAN_CHK: begin
        ram_waddr = cnt;
        ram_wdata = entry & ~IRR_MASK;
        ram_we    = (entry[7:0] == wdata[7:0]);
        if (cnt != LAST) begin
          ram_re    = 1'b1;
          ram_raddr = cnt + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      select_index  <= '0;
      controller_id <= '0;
      valid         <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if ((state == S_FINISH) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        valid_q <= valid[ram_raddr];
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op        <= req.opcode;
            wdata     <= req.write_data;
            result    <= start_result;
            res_ok    <= (req.opcode != OP_QUERY) || query_hit;
            high_half <= sel_rel[0];
            addr      <= (req.opcode == OP_QUERY) ? req.entry_number[AW-1:0]
                                                  : sel_num[AW-1:0];
            cnt       <= '0;
            state     <= start_state;
            if ((req.opcode == OP_WRITE) && (req.offset == OFS_SELECT)) begin
              select_index <= req.write_data[7:0];
            end
            if ((req.opcode == OP_WRITE) && (req.offset == OFS_DATA) &&
                (select_index == IDX_ID)) begin
              controller_id <= req.write_data[27:24];
            end
          end
        end
        S_READ: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (op == OP_READ) begin
            result <= {32'h0, high_half ? entry[63:32] : entry[31:0]};
          end else if (op == OP_QUERY) begin
            result <= entry;
          end
          state <= S_FINISH;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (cnt == LAST) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.read_data <= result;
            rsp.ok        <= res_ok;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `IORF_ASSERT_NOW(a_scan_in_range, state == S_SCAN_CHK, cnt <= LAST, "EOI scan beyond table")
  `IORF_ASSERT_NEXT(a_finish_delivers, (state == S_FINISH) && (!rsp_valid || !rsp_stall),
    rsp_valid && (state == S_IDLE), "finished result not delivered")
  `IORF_ASSERT_NOW(a_bad_query_zero, rsp_valid && !rsp.ok, rsp.read_data == 64'h0,
    "out-of-range query carries data")
  `IORF_ASSERT_NOW(a_bus_read_narrow, (state == S_FINISH) && (op == OP_READ),
    result[63:32] == 32'h0, "bus read wider than 32 bits")

endmodule

`default_nettype wire
